FILE: hdl/iba_pkg.sv
package iba_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DECIMAL     = 6'd10;

    localparam logic [RADIX_W-1:0] LAST_DECIMAL_DIGIT = 6'd9;
    localparam logic [CHAR_W-1:0]  LETTER_GAP         = 7'd7;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO          = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE          = 7'd57;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_A       = 7'd65;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_Z       = 7'd90;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS         = 7'd45;

    // per-word job descriptor handed from front to back
    typedef struct packed {
        logic               neg;
        logic [RADIX_W-1:0] radix;
    } job_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        c = CHAR_ZERO + {1'b0, d};
        if (d > LAST_DECIMAL_DIGIT)
        begin
            c = c + LETTER_GAP;
        end
        return c;
    endfunction

endpackage

FILE: hdl/iba_front.sv
module iba_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radix_we,
    input  logic [iba_pkg::RADIX_W-1:0]  radix_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         q_full,
    output logic                         q_push,
    output logic [VALUE_BITS-1:0]        push_mag,
    output iba_pkg::job_ctrl_t           push_ctrl
);

    logic [iba_pkg::RADIX_W-1:0] radix_reg;
    logic [iba_pkg::RADIX_W-1:0] radix_next;
    logic                        neg;

    always_comb
    begin
        radix_next = radix_reg;
        if (radix_we)
        begin
            if (radix_wdata < iba_pkg::RADIX_MIN)
            begin
                radix_next = iba_pkg::RADIX_MIN;
            end
            else if (radix_wdata > iba_pkg::RADIX_MAX)
            begin
                radix_next = iba_pkg::RADIX_MAX;
            end
            else
            begin
                radix_next = radix_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= iba_pkg::RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // signed only in decimal; magnitude of the most negative value wraps to 2^(N-1)
    assign neg             = (radix_reg == iba_pkg::DECIMAL) && value[VALUE_BITS-1];
    assign push_mag        = neg ? (~value + 1'b1) : value;
    assign push_ctrl.neg   = neg;
    assign push_ctrl.radix = radix_reg;
    assign in_stall        = q_full;
    assign q_push          = in_valid && !q_full;

endmodule

FILE: hdl/iba_queue.sv
module iba_queue #(
    parameter int DATA_W = 39
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/iba_back.sv
module iba_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic [VALUE_BITS-1:0]       pop_mag,
    input  iba_pkg::job_ctrl_t          pop_ctrl,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [iba_pkg::CHAR_W-1:0]  character,
    output logic                        last
);

    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(VALUE_BITS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_SIGN = 5'b00100,
        S_READ = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [VALUE_BITS-1:0]        q_reg;
    logic [VALUE_BITS-1:0]        q_next;
    logic [iba_pkg::RADIX_W-1:0]  rem_reg;
    logic [iba_pkg::RADIX_W-1:0]  rem_next;
    logic [IDX_W-1:0]             bit_cnt_reg;
    logic [IDX_W-1:0]             bit_cnt_next;
    logic [IDX_W-1:0]             nd_reg;
    logic [IDX_W-1:0]             nd_next;
    logic [IDX_W-1:0]             rd_ptr_reg;
    logic [IDX_W-1:0]             rd_ptr_next;
    iba_pkg::job_ctrl_t           ctrl_reg;
    iba_pkg::job_ctrl_t           ctrl_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [iba_pkg::CHAR_W-1:0]   char_reg;
    logic [iba_pkg::CHAR_W-1:0]   char_next;
    logic                         last_reg;
    logic                         last_next;

    logic [iba_pkg::RADIX_W-1:0]  digit_mem [VALUE_BITS];
    logic [iba_pkg::RADIX_W-1:0]  rd_data_reg;
    logic                         mem_we;

    logic [iba_pkg::RADIX_W:0]    rem_sh;
    logic [iba_pkg::RADIX_W:0]    rem_diff;
    logic                         qbit;
    logic [iba_pkg::RADIX_W-1:0]  rem_new;
    logic [VALUE_BITS-1:0]        q_shift;
    logic                         out_free;

    // restoring divide, one quotient bit per cycle
    assign rem_sh   = {rem_reg, q_reg[VALUE_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, ctrl_reg.radix};
    assign qbit     = (rem_sh >= {1'b0, ctrl_reg.radix});
    assign rem_new  = qbit ? rem_diff[iba_pkg::RADIX_W-1:0] : rem_sh[iba_pkg::RADIX_W-1:0];
    assign q_shift  = {q_reg[VALUE_BITS-2:0], qbit};
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        q_next         = q_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        nd_next        = nd_reg;
        rd_ptr_next    = rd_ptr_reg;
        ctrl_next      = ctrl_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        mem_we         = 1'b0;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop        = 1'b1;
                    q_next       = pop_mag;
                    ctrl_next    = pop_ctrl;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    nd_next      = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                q_next = q_shift;
                if (bit_cnt_reg == LAST_BIT)
                begin
                    mem_we       = 1'b1;
                    nd_next      = nd_reg + 1'b1;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    if (q_shift == '0)
                    begin
                        rd_ptr_next = nd_reg;
                        state_next  = ctrl_reg.neg ? S_SIGN : S_READ;
                    end
                end
                else
                begin
                    rem_next     = rem_new;
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = iba_pkg::CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = iba_pkg::digit_char(rd_data_reg);
                    last_next      = (rd_ptr_reg == '0);
                    if (rd_ptr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // digit store, least significant digit at index 0
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[nd_reg] <= rem_new;
        end
        rd_data_reg <= digit_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        ctrl_reg <= ctrl_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            nd_reg        <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            nd_reg        <= nd_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < ctrl_reg.radix))
        else $error("partial remainder not below radix");

    a_digit_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (rd_data_reg < ctrl_reg.radix))
        else $error("stored digit not below radix");

    a_radix_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && $past(state_reg) != S_IDLE) |-> $stable(ctrl_reg))
        else $error("job descriptor changed mid conversion");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (char_reg == iba_pkg::CHAR_MINUS
            || (char_reg >= iba_pkg::CHAR_ZERO && char_reg <= iba_pkg::CHAR_NINE)
            || (char_reg >= iba_pkg::CHAR_UPPER_A && char_reg <= iba_pkg::CHAR_UPPER_Z)))
        else $error("illegal output character");

endmodule

FILE: hdl/integer_to_base_ascii.sv
// channel   direction  handshake            word
// in        sink       in_valid / in_stall  value
// out       source     out_valid/out_stall  character, last
// radix     config     radix_we             radix_wdata (clamped to 2..36)
//
// A value is divided in the bit-serial divider (one quotient bit per cycle)
// one digit at a time; then a '-' for a negative value, then each character
// through the digit store read port, and back to idle for the next word.
// A two-word queue lets the input side accept while the back end works.
// Reset: radix returns to 10, queue and output register empty.
// A stalled output holds its character; the back end waits for it.
module integer_to_base_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radix_we,
    input  logic [iba_pkg::RADIX_W-1:0]  radix_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [iba_pkg::CHAR_W-1:0]   character,
    output logic                         last
);

    localparam int CTRL_W = $bits(iba_pkg::job_ctrl_t);
    localparam int DATA_W = VALUE_BITS + CTRL_W;

    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    logic [VALUE_BITS-1:0] push_mag;
    iba_pkg::job_ctrl_t    push_ctrl;
    logic [DATA_W-1:0]     pop_data;
    logic [VALUE_BITS-1:0] pop_mag;
    iba_pkg::job_ctrl_t    pop_ctrl;

    iba_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .q_full      (q_full),
        .q_push      (q_push),
        .push_mag    (push_mag),
        .push_ctrl   (push_ctrl)
    );

    iba_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_ctrl, push_mag}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign pop_mag  = pop_data[VALUE_BITS-1:0];
    assign pop_ctrl = pop_data[DATA_W-1:VALUE_BITS];

    iba_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .pop_mag   (pop_mag),
        .pop_ctrl  (pop_ctrl),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CHAR_W      = iba_pkg::CHAR_W;
    localparam int RADIX_W     = iba_pkg::RADIX_W;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LONG_HOLD   = 1500;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } text_char_t;

    typedef struct {
        bit                 set_radix;
        logic [RADIX_W-1:0] arg;
        logic [31:0]        word;
        string              text;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     radix_we;
    logic [RADIX_W-1:0]       radix_wdata;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [31:0]       value;
    logic                     out_valid;
    logic                     out_stall;
    logic [CHAR_W-1:0]        character;
    logic                     last;

    text_char_t   pending_text[$];
    stim_row_t    stim_rows[$];
    logic [RADIX_W-1:0] base_reg;
    bit [63:0]    radix_seen;
    bit           tx_eager;
    bit           rx_eager;
    bit           hold_output;
    int           mismatches;
    int           words_sent;
    int           chars_seen;
    int           cycles;
    text_char_t   want;

    integer_to_base_ascii #(.VALUE_BITS(32)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix_we    (radix_we),
        .radix_wdata (radix_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .character   (character),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] d);
        if (d < iba_pkg::RADIX_MIN)
        begin
            return iba_pkg::RADIX_MIN;
        end
        if (d > iba_pkg::RADIX_MAX)
        begin
            return iba_pkg::RADIX_MAX;
        end
        return d;
    endfunction

    function automatic void predict_text(input logic [31:0] w);
        logic [31:0]        mag;
        logic [RADIX_W-1:0] digs [32];
        int                 n;
        bit                 neg;
        text_char_t         tc;
        n = 0;
        neg = (base_reg == iba_pkg::DECIMAL) && w[31];
        mag = neg ? (~w + 32'd1) : w;
        do
        begin
            digs[n] = RADIX_W'(mag % {26'd0, base_reg});
            mag = mag / {26'd0, base_reg};
            n++;
        end
        while (mag != 0);
        if (neg)
        begin
            pending_text.push_back('{iba_pkg::CHAR_MINUS, 1'b0});
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            tc.ch = (digs[k] <= iba_pkg::LAST_DECIMAL_DIGIT)
                  ? iba_pkg::CHAR_ZERO + CHAR_W'(digs[k])
                  : iba_pkg::CHAR_UPPER_A + CHAR_W'(digs[k] - iba_pkg::DECIMAL);
            tc.fin = (k == 0);
            pending_text.push_back(tc);
        end
    endfunction

    function automatic void push_typed_text(input string t);
        for (int i = 0; i < t.len(); i++)
        begin
            pending_text.push_back('{CHAR_W'(t[i]), i == t.len() - 1});
        end
    endfunction

    function automatic logic [31:0] draw_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40);
            1: return -$urandom_range(1, 1000);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // word is accepted at the edge where the task returns
    task automatic offer_word(input logic [31:0] w, input string text);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (text.len() != 0)
        begin
            push_typed_text(text);
        end
        else
        begin
            predict_text(w);
        end
        words_sent++;
    endtask

    task automatic set_base(input logic [RADIX_W-1:0] d);
        in_valid <= 1'b0;
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        radix_we <= 1'b1;
        radix_wdata <= d;
        @(posedge clk);
        radix_we <= 1'b0;
        base_reg = clamp_radix(d);
        radix_seen[base_reg] = 1'b1;
    endtask

    initial
    begin : drain
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_output = 1'b0;
            end
            hold = rx_eager ? 0 : $urandom_range(0, 14);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            chars_seen++;
            if (pending_text.size() == 0)
            begin
                $error("unexpected character %0d, last %0b", character, last);
                mismatches++;
            end
            else
            begin
                want = pending_text.pop_front();
                if (character !== want.ch)
                begin
                    $error("character: expected %0d, got %0d", want.ch, character);
                    mismatches++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0b, got %0b", want.fin, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        radix_we    = 1'b0;
        radix_wdata = '0;
        in_valid    = 1'b0;
        value       = '0;
        tx_eager    = 1'b0;
        rx_eager    = 1'b0;
        hold_output = 1'b0;
        mismatches  = 0;
        words_sent  = 0;
        chars_seen  = 0;
        cycles      = 0;
        base_reg    = iba_pkg::RADIX_RESET;
        radix_seen  = '0;
        radix_seen[iba_pkg::RADIX_RESET] = 1'b1;

        // decimal after reset
        stim_rows.push_back('{1'b0, 6'd0,  32'h0000_0000, "0"});
        stim_rows.push_back('{1'b0, 6'd0,  32'hFFFF_FFFF, "-1"});
        stim_rows.push_back('{1'b0, 6'd0,  32'h8000_0000, "-2147483648"});
        stim_rows.push_back('{1'b0, 6'd0,  32'h7FFF_FFFF, "2147483647"});
        stim_rows.push_back('{1'b0, 6'd0,  32'd9,         "9"});
        stim_rows.push_back('{1'b0, 6'd0,  32'd10,        "10"});
        stim_rows.push_back('{1'b0, 6'd0, -32'sd12345,    ""});
        stim_rows.push_back('{1'b1, 6'd16, 32'h0,         ""});
        stim_rows.push_back('{1'b0, 6'd0,  32'hFFFF_FFFF, "FFFFFFFF"});
        stim_rows.push_back('{1'b0, 6'd0,  32'h8000_0000, "80000000"});
        stim_rows.push_back('{1'b0, 6'd0,  32'hDEAD_BEEF, "DEADBEEF"});
        stim_rows.push_back('{1'b0, 6'd0,  32'h0000_000A, "A"});
        // below range, clamps to binary
        stim_rows.push_back('{1'b1, 6'd0,  32'h0,         ""});
        stim_rows.push_back('{1'b0, 6'd0,  32'h0000_0000, "0"});
        stim_rows.push_back('{1'b0, 6'd0,  32'h0000_0001, "1"});
        stim_rows.push_back('{1'b0, 6'd0,  32'hFFFF_FFFF, "11111111111111111111111111111111"});
        stim_rows.push_back('{1'b0, 6'd0,  32'h5555_5555, ""});
        stim_rows.push_back('{1'b1, 6'd1,  32'h0,         ""});
        stim_rows.push_back('{1'b0, 6'd0,  32'd2,         "10"});
        // above range, clamps to 36
        stim_rows.push_back('{1'b1, 6'd63, 32'h0,         ""});
        stim_rows.push_back('{1'b0, 6'd0,  32'd35,        "Z"});
        stim_rows.push_back('{1'b0, 6'd0,  32'd36,        "10"});
        stim_rows.push_back('{1'b0, 6'd0,  32'hFFFF_FFFF, "1Z141Z3"});
        stim_rows.push_back('{1'b0, 6'd0,  32'h8000_0000, ""});
        stim_rows.push_back('{1'b1, 6'd37, 32'h0,         ""});
        stim_rows.push_back('{1'b0, 6'd0,  32'h7FFF_FFFF, ""});
        stim_rows.push_back('{1'b1, 6'd36, 32'h0,         ""});
        stim_rows.push_back('{1'b0, 6'd0,  32'd10,        "A"});
        stim_rows.push_back('{1'b1, 6'd8,  32'h0,         ""});
        stim_rows.push_back('{1'b0, 6'd0,  32'h8000_0000, "20000000000"});
        stim_rows.push_back('{1'b1, 6'd10, 32'h0,         ""});
        stim_rows.push_back('{1'b0, 6'd0, -32'sd10,       "-10"});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].set_radix)
            begin
                set_base(stim_rows[i].arg);
            end
            else
            begin
                offer_word(stim_rows[i].word, stim_rows[i].text);
            end
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 2))
                0: set_base(iba_pkg::DECIMAL);
                1: set_base(RADIX_W'($urandom_range(2, 36)));
                default: set_base(RADIX_W'($urandom_range(0, 63)));
            endcase
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            // output held off while the input keeps pushing words
            if (ph == 4)
            begin
                tx_eager = 1'b1;
                hold_output = 1'b1;
            end
            repeat (10) offer_word(draw_word(), "");
        end

        in_valid <= 1'b0;
        while (pending_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d words to %0d characters across %0d radix settings",
                 words_sent, chars_seen, $countones(radix_seen));
        $display("Covered decimal sign and extremes, clamped radix writes, stalls both ways");
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
